// File: design/slc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_pkg
// Shared types and codes for the set-associative write-back cache.
// ----------------------------------------------------------------------------
package slc_pkg;

    // Request codes carried on the command field.
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;

    // Controller states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_RESOLVE,
        ST_WB,
        ST_FILL,
        ST_ACC,
        ST_OUT,
        ST_FL_NEXT,
        ST_FL_TAG
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr;
        logic load;
        logic srch_rd;
        logic srch_cmp;
        logic resolve;
        logic wb_step;
        logic fill_step;
        logic acc;
        logic fl_tag_rd;
        logic fl_tag_cap;
        logic fl_inc;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       clr_last;
        logic [1:0] cmd;
        logic       way_last;
        logic       found;
        logic       victim_valid;
        logic       seq_last;
        logic       fl_valid;
        logic       fl_last;
        logic       out_free;
    } t_dp_sts;

endpackage

// File: design/slc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_ctrl
// Sequencer for lookup, write back, fill, access and flush of the cache.
// ----------------------------------------------------------------------------
module slc_ctrl
    import slc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_command,
    output logic       o_ready,
    input  t_dp_sts    i_sts,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_command == CMD_READ || i_command == CMD_WRITE) begin
                        n_state = ST_SRCH_RD;
                    end else if (i_command == CMD_FLUSH) begin
                        n_state = ST_FL_NEXT;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_SRCH_RD:  n_state = ST_SRCH_CMP;
            ST_SRCH_CMP: begin
                n_state = i_sts.way_last ? ST_RESOLVE : ST_SRCH_RD;
            end
            ST_RESOLVE: begin
                if (i_sts.found) begin
                    n_state = ST_ACC;
                end else if (i_sts.victim_valid) begin
                    n_state = ST_WB;
                end else begin
                    n_state = ST_FILL;
                end
            end
            ST_WB: begin
                if (i_sts.seq_last) begin
                    if (i_sts.cmd == CMD_FLUSH) begin
                        n_state = i_sts.fl_last ? ST_OUT : ST_FL_NEXT;
                    end else begin
                        n_state = ST_FILL;
                    end
                end
            end
            ST_FILL: begin
                if (i_sts.seq_last) n_state = ST_ACC;
            end
            ST_ACC: n_state = ST_OUT;
            ST_OUT: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            ST_FL_NEXT: begin
                if (i_sts.fl_valid) begin
                    n_state = ST_FL_TAG;
                end else if (i_sts.fl_last) begin
                    n_state = ST_OUT;
                end
            end
            ST_FL_TAG: n_state = ST_WB;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_CLEAR:    o_cmd.clr = 1'b1;
            ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            ST_SRCH_RD:  o_cmd.srch_rd = 1'b1;
            ST_SRCH_CMP: o_cmd.srch_cmp = 1'b1;
            ST_RESOLVE:  o_cmd.resolve = 1'b1;
            ST_WB: begin
                o_cmd.wb_step = 1'b1;
                o_cmd.fl_inc  = i_sts.seq_last && (i_sts.cmd == CMD_FLUSH) && !i_sts.fl_last;
            end
            ST_FILL:     o_cmd.fill_step = 1'b1;
            ST_ACC:      o_cmd.acc = 1'b1;
            ST_OUT:      o_cmd.out_load = i_sts.out_free;
            ST_FL_NEXT: begin
                o_cmd.fl_tag_rd = i_sts.fl_valid;
                o_cmd.fl_inc    = !i_sts.fl_valid && !i_sts.fl_last;
            end
            ST_FL_TAG:   o_cmd.fl_tag_cap = 1'b1;
            default:     o_cmd = '0;
        endcase
    end

endmodule

// File: design/slc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_dp
// Datapath: tag/age, line and backing memories, search and counters.
// ----------------------------------------------------------------------------
module slc_dp
    import slc_pkg::*;
#(
    parameter int CACHE_BYTES = 4096,
    parameter int LINE_BYTES  = 64,
    parameter int WAYS        = 4,
    parameter int MEM_BYTES   = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_address,
    input  logic [63:0] i_write_data,
    input  logic        i_ready,
    output logic        o_valid,
    output logic [63:0] o_read_data,
    output logic        o_hit,
    output logic [31:0] o_request_count,
    output logic [31:0] o_miss_count
);

    localparam int LWORDS = (LINE_BYTES / 8 > 0) ? LINE_BYTES / 8 : 1;
    localparam int NSETS0 = CACHE_BYTES / LINE_BYTES / WAYS;
    localparam int NSETS  = (NSETS0 > 0) ? NSETS0 : 1;
    localparam int NLINES = NSETS * WAYS;
    localparam int MWORDS = MEM_BYTES / 8;
    localparam int OFFB   = $clog2(LINE_BYTES);
    localparam int SETB   = $clog2(NSETS);
    localparam int SETW   = (SETB > 0) ? SETB : 1;
    localparam int WAYW   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SLOTW  = (NLINES > 1) ? $clog2(NLINES) : 1;
    localparam int WORDW  = (LWORDS > 1) ? $clog2(LWORDS) : 1;
    localparam int SEQW   = $clog2(LWORDS + 1);
    localparam int LWA    = (NLINES * LWORDS > 1) ? $clog2(NLINES * LWORDS) : 1;
    localparam int MAW    = $clog2(MWORDS);
    localparam int TAGB   = 16 - OFFB - SETB;
    localparam int TAGW   = (TAGB > 0) ? TAGB : 1;

    // Request registers.
    logic [1:0]       r_cmd;
    logic [15:0]      r_line;
    logic [WORDW-1:0] r_word;
    logic [63:0]      r_wdata;
    logic [31:0]      r_req;
    logic [31:0]      r_miss;

    // Search and sequencing registers.
    logic [WAYW-1:0]  r_way;
    logic             r_found;
    logic [WAYW-1:0]  r_hit_way;
    logic [WAYW-1:0]  r_vway;
    logic [31:0]      r_vage;
    logic [TAGW-1:0]  r_vtag;
    logic             r_vvalid;
    logic [SLOTW-1:0] r_slot;
    logic [TAGW-1:0]  r_wb_tag;
    logic [SEQW-1:0]  r_seq;
    logic [SLOTW-1:0] r_fl;
    logic [MAW-1:0]   r_clr;
    logic [NLINES-1:0] r_valid;

    // Memories and their registered read data.
    logic [TAGW+31:0] r_tmem [NLINES];
    logic [63:0]      r_lmem [NLINES*LWORDS];
    logic [63:0]      r_bmem [MWORDS];
    logic [TAGW+31:0] r_trd;
    logic [63:0]      r_lrd;
    logic [63:0]      r_brd;

    // Output register.
    logic        r_out_valid;
    logic [63:0] r_out_data;
    logic        r_out_hit;
    logic [31:0] r_out_req;
    logic [31:0] r_out_miss;

    function automatic logic [SLOTW-1:0] f_slot(input logic [WAYW-1:0] way,
                                                input logic [SETW-1:0] set);
        return SLOTW'(32'(way) * NSETS + 32'(set));
    endfunction

    logic [SETW-1:0]  w_set;
    logic [TAGW-1:0]  w_tag;
    logic [SLOTW-1:0] w_srch_slot;
    logic             w_srch_valid;
    logic [31:0]      w_srch_age;
    logic [TAGW-1:0]  w_srch_tag;
    logic [SETW-1:0]  w_wb_set;
    logic             w_seq_rd;
    logic             w_seq_wr;

    assign w_set        = SETW'(r_line % NSETS);
    assign w_tag        = TAGW'(r_line / NSETS);
    assign w_srch_slot  = f_slot(r_way, w_set);
    assign w_srch_valid = r_valid[w_srch_slot];
    assign w_srch_age   = w_srch_valid ? r_trd[31:0] : 32'd0;
    assign w_srch_tag   = r_trd[TAGW+31:32];
    assign w_wb_set     = SETW'(r_slot % NSETS);
    assign w_seq_rd     = (r_seq != SEQW'(LWORDS));
    assign w_seq_wr     = (r_seq != '0);

    // Memory port selection.
    logic             t_we;
    logic [SLOTW-1:0] t_waddr;
    logic             t_re;
    logic [SLOTW-1:0] t_raddr;
    logic             l_we;
    logic [LWA-1:0]   l_waddr;
    logic [63:0]      l_wdata;
    logic             l_re;
    logic [LWA-1:0]   l_raddr;
    logic             b_we;
    logic [MAW-1:0]   b_waddr;
    logic [63:0]      b_wdata;
    logic             b_re;
    logic [MAW-1:0]   b_raddr;

    always_comb begin
        t_we    = i_cmd.acc;
        t_waddr = r_slot;
        t_re    = i_cmd.srch_rd || i_cmd.fl_tag_rd;
        t_raddr = i_cmd.fl_tag_rd ? r_fl : w_srch_slot;

        l_we    = 1'b0;
        l_waddr = LWA'(32'(r_slot) * LWORDS + 32'(r_word));
        l_wdata = r_wdata;
        l_re    = 1'b0;
        l_raddr = LWA'(32'(r_slot) * LWORDS + 32'(r_word));
        if (i_cmd.fill_step) begin
            l_we    = w_seq_wr;
            l_waddr = LWA'(32'(r_slot) * LWORDS + 32'(r_seq) - 32'd1);
            l_wdata = r_brd;
        end else if (i_cmd.acc) begin
            l_we = (r_cmd == CMD_WRITE);
            l_re = (r_cmd == CMD_READ);
        end
        if (i_cmd.wb_step) begin
            l_re    = w_seq_rd;
            l_raddr = LWA'(32'(r_slot) * LWORDS + 32'(r_seq));
        end

        b_we    = 1'b0;
        b_waddr = r_clr;
        b_wdata = 64'd0;
        if (i_cmd.clr) begin
            b_we = 1'b1;
        end else if (i_cmd.wb_step) begin
            b_we    = w_seq_wr;
            b_waddr = MAW'((32'(r_wb_tag) * NSETS + 32'(w_wb_set)) * LWORDS
                           + 32'(r_seq) - 32'd1);
            b_wdata = r_lrd;
        end
        b_re    = i_cmd.fill_step && w_seq_rd;
        b_raddr = MAW'(32'(r_line) * LWORDS + 32'(r_seq));
    end

    // Tag and age memory.
    always_ff @(posedge i_clk) begin
        if (t_we) r_tmem[t_waddr] <= {w_tag, r_req};
        if (t_re) r_trd <= r_tmem[t_raddr];
    end

    // Line word memory.
    always_ff @(posedge i_clk) begin
        if (l_we) r_lmem[l_waddr] <= l_wdata;
        if (l_re) r_lrd <= r_lmem[l_raddr];
    end

    // Backing memory.
    always_ff @(posedge i_clk) begin
        if (b_we) r_bmem[b_waddr] <= b_wdata;
        if (b_re) r_brd <= r_bmem[b_raddr];
    end

    // Request capture and search payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_command;
            r_line  <= 16'(i_address >> OFFB);
            r_word  <= WORDW'((i_address % LINE_BYTES) / 8);
            r_wdata <= i_write_data;
        end
        if (i_cmd.srch_cmp) begin
            if (r_way == '0 || w_srch_age < r_vage) begin
                r_vway   <= r_way;
                r_vage   <= w_srch_age;
                r_vtag   <= w_srch_tag;
                r_vvalid <= w_srch_valid;
            end
            if (w_srch_valid && w_srch_tag == w_tag) r_hit_way <= r_way;
        end
        if (i_cmd.resolve) begin
            r_slot   <= r_found ? f_slot(r_hit_way, w_set) : f_slot(r_vway, w_set);
            r_wb_tag <= r_vtag;
        end
        if (i_cmd.fl_tag_cap) begin
            r_slot   <= r_fl;
            r_wb_tag <= r_trd[TAGW+31:32];
        end
        if (i_cmd.out_load) begin
            r_out_data <= (r_cmd == CMD_READ) ? r_lrd : 64'd0;
            r_out_hit  <= (r_cmd == CMD_READ || r_cmd == CMD_WRITE) && r_found;
            r_out_req  <= r_req;
            r_out_miss <= r_miss;
        end
    end

    // Control registers: counters, valid bits, sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req       <= '0;
            r_miss      <= '0;
            r_way       <= '0;
            r_found     <= 1'b0;
            r_seq       <= '0;
            r_fl        <= '0;
            r_clr       <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) r_clr <= r_clr + MAW'(1);
            if (i_cmd.load) begin
                r_way   <= '0;
                r_found <= 1'b0;
                r_fl    <= '0;
                if (i_command == CMD_READ || i_command == CMD_WRITE) r_req <= r_req + 32'd1;
            end
            if (i_cmd.srch_cmp) begin
                r_way <= r_way + WAYW'(1);
                if (w_srch_valid && w_srch_tag == w_tag) r_found <= 1'b1;
            end
            if (i_cmd.resolve) begin
                r_seq <= '0;
                if (!r_found) r_miss <= r_miss + 32'd1;
            end
            if (i_cmd.fl_tag_cap) r_seq <= '0;
            if (i_cmd.wb_step || i_cmd.fill_step) begin
                r_seq <= w_seq_rd ? r_seq + SEQW'(1) : '0;
            end
            if (i_cmd.fl_inc) r_fl <= r_fl + SLOTW'(1);
            if (i_cmd.acc) r_valid[r_slot] <= 1'b1;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Status to the controller.
    always_comb begin
        o_sts.clr_last     = (r_clr == MAW'(MWORDS - 1));
        o_sts.cmd          = r_cmd;
        o_sts.way_last     = (r_way == WAYW'(WAYS - 1));
        o_sts.found        = r_found;
        o_sts.victim_valid = r_vvalid;
        o_sts.seq_last     = !w_seq_rd;
        o_sts.fl_valid     = r_valid[r_fl];
        o_sts.fl_last      = (r_fl == SLOTW'(NLINES - 1));
        o_sts.out_free     = !r_out_valid || i_ready;
    end

    assign o_valid         = r_out_valid;
    assign o_read_data     = r_out_data;
    assign o_hit           = r_out_hit;
    assign o_request_count = r_out_req;
    assign o_miss_count    = r_out_miss;

endmodule

// File: design/set_assoc_lru_writeback_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache
// Set-associative write-back cache of 64-bit words with timestamp LRU.
// ----------------------------------------------------------------------------
// Usage: one request item enters on i_valid/o_ready (command, byte address,
// write data) and one result item leaves on o_valid/i_ready (read data, hit,
// request and miss counts). One item is worked on at a time; o_ready is high
// only while the sequencer is idle.
// Sequence: the ways of the set are searched one at a time through the tag
// and age memory, a read and then a compare for each way. A hit then goes
// to the word access and presents its result in the same cycle in which the
// block is ready again. A miss adds a fill of the line from the backing
// memory and, if the victim is loaded, a write back of it before the fill.
// A flush visits every line slot in turn and writes each loaded one back
// word by word.
// Reset: the backing memory is cleared one word per cycle, every word of it,
// before the first item is accepted.
// Stall: the result waits in an output register; the block returns to idle
// once the result has been loaded, and holds a later result until the
// receiver has taken the earlier one.
// ----------------------------------------------------------------------------
module set_assoc_lru_writeback_cache
    import slc_pkg::*;
#(
    parameter int CACHE_BYTES = 4096,
    parameter int LINE_BYTES  = 64,
    parameter int WAYS        = 4,
    parameter int MEM_BYTES   = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_address,
    input  logic [63:0] i_write_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_read_data,
    output logic        o_hit,
    output logic [31:0] o_request_count,
    output logic [31:0] o_miss_count
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer.
    slc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .o_ready   (o_ready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    // Memories, search and counters.
    slc_dp #(
        .CACHE_BYTES (CACHE_BYTES),
        .LINE_BYTES  (LINE_BYTES),
        .WAYS        (WAYS),
        .MEM_BYTES   (MEM_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_command       (i_command),
        .i_address       (i_address),
        .i_write_data    (i_write_data),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_read_data     (o_read_data),
        .o_hit           (o_hit),
        .o_request_count (o_request_count),
        .o_miss_count    (o_miss_count)
    );

`ifndef SYNTHESIS
    // An accepted item makes the block busy in the next cycle.
    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> !o_ready)
        else $error("block still ready after accepting an item");

    // Loading a result always presents it in the next cycle.
    a_out_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> o_valid)
        else $error("result not presented after load");

    // A hit goes straight to the word access, with no write back or fill.
    a_hit_to_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.resolve && w_sts.found |=> w_cmd.acc)
        else $error("hit did not go straight to the access");
`endif

endmodule
